// ===== rtl/grr_pkg.sv =====
// Package with the shared types and constants of the gesture record and replay block.
`default_nettype none

package grr_pkg;

    // Default sizes of the point table and the time stamps.
    localparam int unsigned POINT_DEPTH_DEF = 1024;
    localparam int unsigned TIME_BITS_DEF   = 32;

    // Field widths.
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned SLEW_W  = 24;
    localparam int unsigned MV_W    = 15;
    localparam int unsigned STEP_W  = 24;
    localparam int unsigned OP_W    = 2;

    // Stream and register port widths.
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 4;

    // Register reset values.
    localparam logic [STEP_W-1:0] RISE_STEP_RST = 24'd699;
    localparam logic [STEP_W-1:0] FALL_STEP_RST = 24'd699;
    localparam logic [MV_W-1:0]   TRIG_HIGH_RST = 15'sd1000;
    localparam logic [MV_W-1:0]   TRIG_LOW_RST  = 15'sd0;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_DRAG    = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_RISE_STEP = 2'd0,
        REG_FALL_STEP = 2'd1,
        REG_TRIG_HIGH = 2'd2,
        REG_TRIG_LOW  = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/grr_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module grr_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first: a read and a write of the same entry in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/gesture_record_replay.sv =====
// Top level of the gesture record and replay block: event handling, replay and slew.
//
//  channel   direction  handshake              payload
//  s stream  in         i_s_tvalid/o_s_tready  tdata level,trig_voltage,button; tuser op
//  m stream  out        o_m_tvalid/i_m_tready  tdata cv_out,gate_out,store_full
//  apb       in/out     psel/penable/pready    four registers at byte addresses 0,4,8,12
//
// An item is taken when tvalid meets tready; a tick item puts its result into the output
// register at the same edge, so items flow at one per cycle unless the input stalls.
// The point table is read every cycle at the replay index the next item will use.
// After a table write to that same entry the input stalls for a fresh read, as it
// also does after reset. Reset is synchronous; the table is not cleared.
// The input stalls while the output register holds a result not yet taken.
`default_nettype none

module gesture_record_replay #(
    parameter int unsigned POINT_DEPTH = grr_pkg::POINT_DEPTH_DEF,
    parameter int unsigned TIME_BITS   = grr_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [15:0] level, [30:16] trig_voltage, [31] button
    input  wire logic [grr_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [1:0] op
    input  wire logic [grr_pkg::OP_W-1:0]      i_s_tuser,
    // result items
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [15:0] cv_out, [16] gate_out, [17] store_full, [23:18] zero
    output logic      [grr_pkg::M_DATA_W-1:0]  o_m_tdata,
    // configuration
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [grr_pkg::APB_AW-1:0]    i_paddr,
    input  wire logic [grr_pkg::APB_DW-1:0]    i_pwdata,
    output logic      [grr_pkg::APB_DW-1:0]    o_prdata,
    output logic                               o_pready
);

    localparam int unsigned AW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
    localparam int unsigned CW = $clog2(POINT_DEPTH + 1);
    localparam int unsigned LW = grr_pkg::LEVEL_W;
    localparam int unsigned SW = grr_pkg::SLEW_W;
    localparam int unsigned MW = grr_pkg::MV_W;
    localparam int unsigned PW = TIME_BITS + LW;

    // ---------------- configuration registers ----------------
    logic [grr_pkg::STEP_W-1:0] r_rise_step, r_fall_step;
    logic signed [MW-1:0]       r_trig_high, r_trig_low;
    logic                       cfg_we;
    grr_pkg::t_reg_idx          cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_we   = i_psel & i_penable & i_pwrite & o_pready;
    assign cfg_idx  = grr_pkg::t_reg_idx'(i_paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_step <= grr_pkg::RISE_STEP_RST;
            r_fall_step <= grr_pkg::FALL_STEP_RST;
            r_trig_high <= grr_pkg::TRIG_HIGH_RST;
            r_trig_low  <= grr_pkg::TRIG_LOW_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                grr_pkg::REG_RISE_STEP: r_rise_step <= i_pwdata[grr_pkg::STEP_W-1:0];
                grr_pkg::REG_FALL_STEP: r_fall_step <= i_pwdata[grr_pkg::STEP_W-1:0];
                grr_pkg::REG_TRIG_HIGH: r_trig_high <= i_pwdata[MW-1:0];
                grr_pkg::REG_TRIG_LOW:  r_trig_low  <= i_pwdata[MW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            grr_pkg::REG_RISE_STEP:
                o_prdata = {{(grr_pkg::APB_DW - grr_pkg::STEP_W){1'b0}}, r_rise_step};
            grr_pkg::REG_FALL_STEP:
                o_prdata = {{(grr_pkg::APB_DW - grr_pkg::STEP_W){1'b0}}, r_fall_step};
            grr_pkg::REG_TRIG_HIGH:
                o_prdata = {{(grr_pkg::APB_DW - MW){r_trig_high[MW-1]}}, r_trig_high};
            grr_pkg::REG_TRIG_LOW:
                o_prdata = {{(grr_pkg::APB_DW - MW){r_trig_low[MW-1]}}, r_trig_low};
        endcase
    end

    // ---------------- state ----------------
    logic [CW-1:0]        r_point_count, n_point_count;
    logic [CW-1:0]        r_play_index, n_play_index;
    logic [LW-1:0]        r_cur_level, n_cur_level;
    logic [LW-1:0]        r_prev_level, n_prev_level;
    logic [SW-1:0]        r_slew, n_slew;
    logic [TIME_BITS-1:0] r_record_time, n_record_time;
    logic [TIME_BITS-1:0] r_play_time, n_play_time;
    logic                 r_gate, n_gate;
    logic                 r_replaying, n_replaying;
    logic                 r_recording, n_recording;
    logic                 r_trig_hi, n_trig_hi;
    logic                 r_btn_hi, n_btn_hi;
    logic                 r_dropped, n_dropped;
    logic                 r_rd_ok;
    logic [PW-1:0]        r_entry0;
    logic                 r_out_valid, n_out_valid;
    logic [grr_pkg::M_DATA_W-1:0] r_out_data, n_out_data;

    // point table port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [PW-1:0] ram_wdata, ram_rdata;

    // input fields
    grr_pkg::t_op         in_op;
    logic [LW-1:0]        in_level;
    logic signed [MW-1:0] in_trig;
    logic                 in_button;
    logic                 accept;

    assign in_op     = grr_pkg::t_op'(i_s_tuser);
    assign in_level  = i_s_tdata[LW-1:0];
    assign in_trig   = i_s_tdata[LW+MW-1:LW];
    assign in_button = i_s_tdata[LW+MW];

    assign o_s_tready = r_rd_ok & (~r_out_valid | i_m_tready);
    assign accept     = i_s_tvalid & o_s_tready;

    grr_ram #(
        .WIDTH(PW),
        .DEPTH(POINT_DEPTH)
    ) u_points (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // The read always targets the entry that the next item will step on.
    assign ram_raddr = n_play_index[AW-1:0];

    always_comb begin
        logic                 trig_edge;
        logic                 btn_edge;
        logic                 start;
        logic                 do_append;
        logic                 table_full;
        logic [CW-1:0]        pidx;
        logic [TIME_BITS-1:0] ptime;
        logic [PW-1:0]        entry;
        logic [SW-1:0]        target;
        logic [SW-1:0]        s;
        logic [SW:0]          lo_sum;
        logic [SW:0]          hi_sum;

        n_point_count = r_point_count;
        n_play_index  = r_play_index;
        n_cur_level   = r_cur_level;
        n_prev_level  = r_prev_level;
        n_slew        = r_slew;
        n_record_time = r_record_time;
        n_play_time   = r_play_time;
        n_gate        = r_gate;
        n_replaying   = r_replaying;
        n_recording   = r_recording;
        n_trig_hi     = r_trig_hi;
        n_btn_hi      = r_btn_hi;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid & ~i_m_tready;
        n_out_data    = r_out_data;
        do_append     = 1'b0;
        table_full    = (r_point_count == CW'(POINT_DEPTH));

        // Schmitt detectors.
        trig_edge = ~r_trig_hi & (in_trig >= r_trig_high);
        btn_edge  = ~r_btn_hi & in_button;
        start     = (trig_edge & ~r_recording) | btn_edge;
        pidx      = start ? '0 : r_play_index;
        ptime     = start ? '0 : r_play_time;
        // A replay that starts in this tick looks at entry zero, kept in a side copy.
        entry     = start ? r_entry0 : ram_rdata;
        target    = '0;
        s         = '0;
        lo_sum    = '0;
        hi_sum    = '0;

        if (accept) begin
            unique case (in_op)
                grr_pkg::OP_PRESS: begin
                    n_gate        = 1'b1;
                    n_replaying   = 1'b0;
                    n_record_time = '0;
                    n_recording   = 1'b1;
                    n_point_count = '0;
                    n_dropped     = 1'b0;
                    n_slew        = {in_level, 8'h00};
                    n_cur_level   = in_level;
                end
                grr_pkg::OP_DRAG: begin
                    n_cur_level = in_level;
                end
                grr_pkg::OP_RELEASE: begin
                    do_append   = 1'b1;
                    n_gate      = 1'b0;
                    n_recording = 1'b0;
                end
                grr_pkg::OP_TICK: begin
                    n_trig_hi = r_trig_hi ? ~(in_trig <= r_trig_low) : trig_edge;
                    n_btn_hi  = in_button;
                    n_replaying  = r_replaying | start;
                    n_gate       = r_gate | start;
                    n_play_index = pidx;
                    s            = r_slew;
                    if (!n_replaying) begin
                        if (r_prev_level != r_cur_level) begin
                            do_append    = n_gate;
                            n_prev_level = r_cur_level;
                        end
                    end else if (pidx >= r_point_count) begin
                        n_replaying = 1'b0;
                        n_gate      = 1'b0;
                    end else if (ptime == entry[TIME_BITS-1:0]) begin
                        if (pidx + CW'(1) == r_point_count) begin
                            n_replaying = 1'b0;
                            n_gate      = 1'b0;
                        end
                        n_cur_level = entry[PW-1:TIME_BITS];
                        if (ptime == '0) begin
                            s = {entry[PW-1:TIME_BITS], 8'h00};
                        end
                        n_play_index = pidx + CW'(1);
                    end

                    // Slew limiting toward the target, never passing it.
                    target = {n_cur_level, 8'h00};
                    lo_sum = {1'b0, target} + {1'b0, r_fall_step};
                    hi_sum = {1'b0, s} + {1'b0, r_rise_step};
                    priority if (lo_sum < {1'b0, s}) begin
                        n_slew = s - r_fall_step;
                    end else if ({1'b0, target} > hi_sum) begin
                        n_slew = hi_sum[SW-1:0];
                    end else begin
                        n_slew = target;
                    end

                    // A point dropped by this very tick already shows in its result.
                    n_out_valid   = 1'b1;
                    n_out_data    = {{(grr_pkg::M_DATA_W - LW - 2){1'b0}},
                                     n_dropped | (do_append & table_full), n_gate,
                                     ~n_slew[SW-1:8]};
                    n_record_time = r_record_time + TIME_BITS'(1);
                    n_play_time   = ptime + TIME_BITS'(1);
                end
            endcase
        end

        // Appends to a full table are dropped and flagged.
        ram_we    = 1'b0;
        ram_waddr = r_point_count[AW-1:0];
        ram_wdata = {r_cur_level, r_record_time};
        if (do_append) begin
            if (table_full) begin
                n_dropped = 1'b1;
            end else begin
                ram_we        = 1'b1;
                n_point_count = r_point_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_play_index  <= '0;
            r_cur_level   <= grr_pkg::LEVEL_FULL;
            r_prev_level  <= grr_pkg::LEVEL_FULL;
            r_slew        <= '0;
            r_record_time <= '0;
            r_play_time   <= '0;
            r_gate        <= 1'b0;
            r_replaying   <= 1'b0;
            r_recording   <= 1'b0;
            r_trig_hi     <= 1'b0;
            r_btn_hi      <= 1'b0;
            r_dropped     <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_point_count <= n_point_count;
            r_play_index  <= n_play_index;
            r_cur_level   <= n_cur_level;
            r_prev_level  <= n_prev_level;
            r_slew        <= n_slew;
            r_record_time <= n_record_time;
            r_play_time   <= n_play_time;
            r_gate        <= n_gate;
            r_replaying   <= n_replaying;
            r_recording   <= n_recording;
            r_trig_hi     <= n_trig_hi;
            r_btn_hi      <= n_btn_hi;
            r_dropped     <= n_dropped;
            // A write to the entry being read leaves stale data in the read register.
            r_rd_ok       <= ~(ram_we & (ram_waddr == ram_raddr));
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (ram_we && ram_waddr == '0) begin
            r_entry0 <= ram_wdata;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point_count <= CW'(POINT_DEPTH))
        else $error("point count beyond table depth");

    a_gate_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate |-> (r_recording || r_replaying))
        else $error("gate open while neither recording nor replaying");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_replaying |-> (r_play_index <= r_point_count))
        else $error("replay index beyond point count");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_op == grr_pkg::OP_TICK) |=> o_m_tvalid)
        else $error("tick item gave no result");

endmodule

`default_nettype wire

// ===== tb/tb_gesture_record_replay.sv =====
// Self-checking testbench for the gesture record and replay block.

module tb_gesture_record_replay;
    import grr_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        bit        full;
        bit        gate;
        bit [15:0] cv;
    } cv_result_t;

    // Predicts the CV, gate and drop flag of every tick and checks them in order.
    class gesture_scoreboard;
        bit [31:0]   stamp_tab [POINT_DEPTH_DEF];
        bit [15:0]   level_tab [POINT_DEPTH_DEF];
        int unsigned fill;
        int unsigned play_pos;
        bit [15:0]   live_level;
        bit [15:0]   last_level;
        bit [23:0]   slew;
        bit [31:0]   rec_clock;
        bit [31:0]   play_clock;
        bit          gate;
        bit          playing;
        bit          taking;
        bit          trig_st;
        bit          btn_st;
        bit          lost;
        bit [23:0]   rise;
        bit [23:0]   fall;
        int          thr_hi;
        int          thr_lo;
        cv_result_t  cv_q[$];
        int          errors;

        function new();
            fill       = 0;
            play_pos   = 0;
            live_level = LEVEL_FULL;
            last_level = LEVEL_FULL;
            slew       = '0;
            rec_clock  = '0;
            play_clock = '0;
            gate       = 1'b0;
            playing    = 1'b0;
            taking     = 1'b0;
            trig_st    = 1'b0;
            btn_st     = 1'b0;
            lost       = 1'b0;
            rise       = RISE_STEP_RST;
            fall       = FALL_STEP_RST;
            thr_hi     = int'($signed(TRIG_HIGH_RST));
            thr_lo     = int'($signed(TRIG_LOW_RST));
            errors     = 0;
        endfunction

        function void set_register(t_reg_idx idx, bit [31:0] value);
            case (idx)
                REG_RISE_STEP: rise = value[23:0];
                REG_FALL_STEP: fall = value[23:0];
                REG_TRIG_HIGH: thr_hi = int'($signed(value[14:0]));
                REG_TRIG_LOW:  thr_lo = int'($signed(value[14:0]));
                default: ;
            endcase
        endfunction

        function void add_point();
            if (fill < POINT_DEPTH_DEF) begin
                stamp_tab[fill] = rec_clock;
                level_tab[fill] = live_level;
                fill++;
            end else begin
                lost = 1'b1;
            end
        endfunction

        function bit schmitt_edge(inout bit st, input int v, input int lo, input int hi);
            if (st) begin
                if (v <= lo)
                    st = 1'b0;
                return 1'b0;
            end
            if (v >= hi) begin
                st = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(t_op op, bit [15:0] lvl, bit [14:0] mv, bit btn);
            bit         t_edge;
            bit         b_edge;
            longint     tgt;
            longint     lo;
            longint     hi;
            longint     s;
            cv_result_t r;

            case (op)
                OP_PRESS: begin
                    gate       = 1'b1;
                    playing    = 1'b0;
                    rec_clock  = '0;
                    taking     = 1'b1;
                    fill       = 0;
                    lost       = 1'b0;
                    slew       = {lvl, 8'h00};
                    live_level = lvl;
                    return;
                end
                OP_DRAG: begin
                    live_level = lvl;
                    return;
                end
                OP_RELEASE: begin
                    add_point();
                    gate   = 1'b0;
                    taking = 1'b0;
                    return;
                end
                default: ;
            endcase

            t_edge = schmitt_edge(trig_st, int'($signed(mv)), thr_lo, thr_hi);
            b_edge = schmitt_edge(btn_st, int'(btn), 0, 1);
            if ((t_edge && !taking) || b_edge) begin
                playing    = 1'b1;
                play_clock = '0;
                play_pos   = 0;
                gate       = 1'b1;
            end

            if (!playing) begin
                if (last_level != live_level) begin
                    if (gate)
                        add_point();
                    last_level = live_level;
                end
            end else if (play_pos >= fill) begin
                playing = 1'b0;
                gate    = 1'b0;
            end else if (play_clock == stamp_tab[play_pos]) begin
                if (play_pos == fill - 1) begin
                    playing = 1'b0;
                    gate    = 1'b0;
                end
                live_level = level_tab[play_pos];
                // A point stamped at the very start of a take is played without slew.
                if (play_clock == 0)
                    slew = {live_level, 8'h00};
                play_pos++;
            end

            tgt = longint'({live_level, 8'h00});
            s   = longint'(slew);
            lo  = s - longint'(fall);
            hi  = s + longint'(rise);
            if (tgt < lo)
                s = lo;
            else if (tgt > hi)
                s = hi;
            else
                s = tgt;
            slew = s[23:0];

            r.cv   = 16'hFFFF - slew[23:8];
            r.gate = gate;
            r.full = lost;
            cv_q.push_back(r);

            rec_clock++;
            play_clock++;
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(bit [23:0] data);
            cv_result_t want;

            if (cv_q.size() == 0) begin
                report($sformatf("result %h arrived with nothing expected", data));
                return;
            end
            want = cv_q.pop_front();
            if (data[15:0] != want.cv)
                report($sformatf("cv_out %0d, expected %0d", data[15:0], want.cv));
            if (data[16] != want.gate)
                report($sformatf("gate_out %0d, expected %0d", data[16], want.gate));
            if (data[17] != want.full)
                report($sformatf("store_full %0d, expected %0d", data[17], want.full));
        endtask

        function int pending();
            return cv_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    // [15:0] level, [30:16] trig_voltage, [31] button
    logic [S_DATA_W-1:0] i_s_tdata;
    // [1:0] op
    logic [OP_W-1:0]     i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    // [15:0] cv_out, [16] gate_out, [17] store_full, [23:18] zero
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                i_psel;
    logic                i_penable;
    logic                i_pwrite;
    logic [APB_AW-1:0]   i_paddr;
    logic [APB_DW-1:0]   i_pwdata;
    logic [APB_DW-1:0]   o_prdata;
    logic                o_pready;

    gesture_scoreboard sb;
    int                item_count  = 0;
    int                send_streak = 0;
    int                cfg_trig_low = 0;
    bit                hold_asked  = 1'b0;

    gesture_record_replay dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int streak);
        int r;

        if (streak > 0) begin
            streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            streak = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int rand_mv();
        return int'($urandom_range(0, 24000)) - 12000;
    endfunction

    // A trigger sample at or below the current low threshold of the Schmitt input.
    function automatic int quiet_mv();
        return int'($urandom_range(0, cfg_trig_low + 12000)) - 12000;
    endfunction

    function automatic bit [15:0] rand_level();
        int r;

        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Leaves tvalid high on return so that a back-to-back item needs no second assignment.
    task automatic send_item(t_op op, bit [15:0] lvl, int mv, bit btn);
        int          gap;
        logic [14:0] mv_bits;

        mv_bits = mv[14:0];
        gap = pick_gap(send_streak);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {btn, mv_bits, lvl};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(op, lvl, mv_bits, btn);
        item_count++;
    endtask

    task automatic tick(int mv, bit btn);
        send_item(OP_TICK, rand_level(), mv, btn);
    endtask

    task automatic write_reg(t_reg_idx idx, int value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        sb.set_register(idx, value);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // Drains all expected results, then gives a release-only tail time to settle.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic configure(int rise, int fall, int hi, int lo);
        write_reg(REG_RISE_STEP, rise);
        write_reg(REG_FALL_STEP, fall);
        write_reg(REG_TRIG_HIGH, hi);
        write_reg(REG_TRIG_LOW, lo);
        cfg_trig_low = lo;
    endtask

    // One recorded gesture followed by an attempt to replay it.
    task automatic gesture_take();
        int steps;
        int ticks_rec;
        int k;

        ticks_rec = 0;
        send_item(OP_PRESS, rand_level(), rand_mv(), 1'($urandom_range(0, 1)));
        steps = $urandom_range(1, 6);
        repeat (steps) begin
            if ($urandom_range(0, 3) != 0)
                send_item(OP_DRAG, rand_level(), rand_mv(), 1'($urandom_range(0, 1)));
            k = $urandom_range(1, 4);
            repeat (k) begin
                tick(quiet_mv(), $urandom_range(0, 9) == 0);
                ticks_rec++;
            end
        end
        send_item(OP_RELEASE, rand_level(), rand_mv(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) != 0)
            tick(12000, 1'b0);
        else
            tick(quiet_mv(), 1'b1);
        repeat (ticks_rec + $urandom_range(0, 3)) tick(quiet_mv(), 1'b0);
    endtask

    task automatic random_part(int n);
        int start;

        start = item_count;
        while (item_count - start < n) begin
            if ($urandom_range(0, 4) == 0)
                send_item(t_op'($urandom_range(0, 3)), rand_level(), rand_mv(),
                          1'($urandom_range(0, 1)));
            else
                gesture_take();
        end
    endtask

    // Result side: random stalls, plus one long hold that backs up the whole block.
    initial begin
        int  stall;
        int  streak;
        bit  hold_done;

        stall     = 0;
        streak    = 0;
        hold_done = 1'b0;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_m_tready && o_m_tvalid)
                sb.check_result(o_m_tdata);
            if (hold_asked && !hold_done) begin
                hold_done = 1'b1;
                stall = LONG_HOLD;
            end else if (stall > 0) begin
                stall--;
            end else begin
                stall = pick_gap(streak);
            end
            i_m_tready <= (stall == 0);
        end
    end

    initial begin
        int idle;

        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_psel && i_penable && o_pready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_TICK;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: Schmitt thresholds at and around their edges, replay of an
        // empty table, a release with no press, button replay while recording,
        // and a replay of the take just recorded.
        tick(0, 1'b0);
        tick(12000, 1'b0);
        tick(1000, 1'b0);
        tick(0, 1'b0);
        tick(1000, 1'b0);
        tick(1, 1'b0);
        tick(-12000, 1'b1);
        tick(-12000, 1'b0);
        send_item(OP_RELEASE, 16'h1234, -12000, 1'b1);
        tick(-1, 1'b1);
        tick(-1, 1'b0);
        send_item(OP_PRESS, 16'h0000, 12000, 1'b0);
        send_item(OP_DRAG, 16'hFFFF, -12000, 1'b1);
        tick(-5, 1'b0);
        tick(-5, 1'b0);
        send_item(OP_DRAG, 16'h3039, 0, 1'b0);
        tick(12000, 1'b0);
        tick(-12000, 1'b1);
        tick(-12000, 1'b0);
        send_item(OP_RELEASE, 16'hAAAA, 0, 1'b0);
        tick(-12000, 1'b1);
        repeat (4) tick(-12000, 1'b0);

        // Overflow the point table, then replay it and clear the drop flag.
        send_item(OP_PRESS, 16'h8000, 0, 1'b0);
        repeat (POINT_DEPTH_DEF + 6)
            send_item(OP_RELEASE, rand_level(), rand_mv(), 1'($urandom_range(0, 1)));
        tick(-12000, 1'b0);
        tick(-12000, 1'b1);
        repeat (3) tick(-12000, 1'b0);
        send_item(OP_PRESS, 16'h4000, 0, 1'b0);
        tick(-12000, 1'b0);

        for (int p = 0; p < 5; p++) begin
            int hi;

            wait_idle();
            case (p)
                0: configure(0, 0, 12000, -12000);
                1: configure(24'hFFFFFF, 24'hFFFFFF, -12000, 12000);
                2: begin
                    hi = $urandom_range(0, 12000);
                    configure($urandom_range(1, 4000), $urandom_range(1, 4000), hi,
                              int'($urandom_range(0, hi + 12000)) - 12000);
                    hold_asked = 1'b1;
                end
                3: configure(1, 24'hFFFFFF, 0, 0);
                default: begin
                    hi = $urandom_range(0, 12000);
                    configure($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                              hi, int'($urandom_range(0, hi + 12000)) - 12000);
                end
            endcase
            random_part(120);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
